FILE: design/auto_ranging_lux_calculator_macros.svh
// ----------------------------------------------------------------------------
// Lux calculator assertion macros
// Checks are clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef AUTO_RANGING_LUX_CALCULATOR_MACROS_SVH
`define AUTO_RANGING_LUX_CALCULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define ARL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lux calculator check failed");
// condition must never be seen
`define ARL_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lux calculator forbidden condition");
`else
`define ARL_ASSERT(label, prop)
`define ARL_ASSERT_NEVER(label, cond)
`endif
`endif

FILE: design/arl_pkg.sv
// ----------------------------------------------------------------------------
// Lux calculator package
// Types, constants, profile ROM and power table generator.
// ----------------------------------------------------------------------------
package arl_pkg;

  localparam int MAX_STEPS_DEF   = 6;
  localparam int POW_ENTRIES_DEF = 64;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 35;
  localparam int DIV_D_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Q24 coefficients
  localparam logic [20:0] COEF_P0 = 21'd510027;
  localparam logic [20:0] COEF_P1 = 21'd1040187;
  localparam logic [20:0] COEF_BA = 21'd375810;
  localparam logic [20:0] COEF_BB = 21'd520094;
  localparam logic [20:0] COEF_CA = 21'd214748;
  localparam logic [20:0] COEF_CB = 21'd256691;
  localparam logic [20:0] COEF_DA = 21'd24495;
  localparam logic [20:0] COEF_DB = 21'd18790;

  // Q16 scale factors
  localparam logic [34:0] SCALE_T0  = 35'd1923027;
  localparam logic [34:0] SCALE_T1  = 35'd260846;
  localparam logic [34:0] SCALE_T2  = 35'd65536;
  localparam logic [34:0] SCALE_NUM = 35'd26345472000;

  typedef enum logic [2:0] {
    CFG_RANGE_PROFILE,
    CFG_LOW_LIMIT,
    CFG_HIGH_LIMIT,
    CFG_FIXED_HIGH_GAIN,
    CFG_FIXED_TIMING,
    CFG_MANUAL_TIME_US,
    CFG_SETTLE_MS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TIM_13MS,
    TIM_101MS,
    TIM_402MS,
    TIM_MANUAL
  } timing_t;

  typedef enum logic [2:0] {
    RGN_POW,
    RGN_B,
    RGN_C,
    RGN_D,
    RGN_NONE
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_R,
    S_MUL_D,
    S_MUL_P,
    S_MUL_R1,
    S_MUL_A,
    S_MUL_B,
    S_SCALE,
    S_MUL_L,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [2:0] prof_len(input logic [1:0] p);
    case (p)
      2'd0:    return 3'd1;
      2'd1:    return 3'd6;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic prof_gain(input logic [1:0] p, input logic [2:0] s);
    logic g;
    g = 1'b0;
    case (p)
      2'd1:    g = (s == 3'd2) || (s == 3'd4) || (s == 3'd5);
      2'd2:    g = (s == 3'd1) || (s == 3'd2) || (s == 3'd3);
      2'd3:    g = (s == 3'd3);
      default: g = 1'b0;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] prof_time(input logic [1:0] p, input logic [2:0] s);
    logic [1:0] t;
    t = TIM_13MS;
    case (p)
      2'd1: begin
        case (s)
          3'd1, 3'd4: t = TIM_101MS;
          3'd3, 3'd5: t = TIM_402MS;
          default:    t = TIM_13MS;
        endcase
      end
      2'd2: begin
        case (s)
          3'd2:    t = TIM_101MS;
          3'd3:    t = TIM_402MS;
          default: t = TIM_13MS;
        endcase
      end
      2'd3: begin
        case (s)
          3'd1:       t = TIM_101MS;
          3'd2, 3'd3: t = TIM_402MS;
          default:    t = TIM_13MS;
        endcase
      end
      default: t = TIM_13MS;
    endcase
    return t;
  endfunction

  // x^1.4 in Q16 for x = x_in/65536, elaboration use only
  function automatic logic [15:0] pow_entry(input int unsigned x_in);
    logic [63:0] x, t2, lo, hi, mid, y2, y4, f;
    x  = 64'(x_in);
    t2 = (x * x) >> 16;
    lo = 64'd0;
    hi = 64'd65536;
    for (int k = 0; k < 18; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        y2  = (mid * mid) >> 16;
        y4  = (y2 * y2) >> 16;
        f   = (y4 * mid) >> 16;
        if (f <= t2) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return 16'((x * lo) >> 16);
  endfunction

endpackage

FILE: design/arl_channels.sv
// ----------------------------------------------------------------------------
// Lux calculator channels
// Sample, result and configuration write channels.
// ----------------------------------------------------------------------------
interface arl_sample_if import arl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] count0;
  logic [15:0] count1;
  logic [15:0] elapsed_ms;
  modport source (output valid, count0, count1, elapsed_ms, input ready);
  modport sink   (input valid, count0, count1, elapsed_ms, output ready);
endinterface

interface arl_result_if import arl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] lux_q8;
  logic               saturated;
  logic               gain_high;
  logic [1:0]         timing_sel;
  logic [2:0]         step_index;
  logic               range_changed;
  logic [15:0]        count0_echo;
  logic [15:0]        count1_echo;
  modport source (output valid, lux_q8, saturated, gain_high, timing_sel, step_index,
                  range_changed, count0_echo, count1_echo, input ready);
  modport sink   (input valid, lux_q8, saturated, gain_high, timing_sel, step_index,
                  range_changed, count0_echo, count1_echo, output ready);
endinterface

interface arl_cfg_if import arl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/arl_div.sv
// ----------------------------------------------------------------------------
// Lux calculator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arl_div import arl_pkg::*; #(
  parameter int N_W = DIV_N_W,
  parameter int D_W = DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [N_W-1:0] quotient,
  output unit_stat_t     stat
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     rem_sub;
  logic             fits;

  assign rem_sh  = {rem, quo[N_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N_W-2:0], fits};
      rem <= fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

FILE: design/arl_mul.sv
// ----------------------------------------------------------------------------
// Lux calculator multiplier
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module arl_mul import arl_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] product,
  output unit_stat_t         stat
);
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   a_sh;
  logic [B_W-1:0]   b_sh;
  logic [P_W-1:0]   acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= P_W'(a);
      b_sh <= b;
      acc  <= '0;
    end else if (busy) begin
      if (b_sh[0]) acc <= acc + a_sh;
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

FILE: design/auto_ranging_lux_calculator.sv
// ----------------------------------------------------------------------------
// Auto-ranging lux calculator
// Datasheet lux formula on a sensor count pair, with profile auto-ranging.
// ----------------------------------------------------------------------------
// Usage:
//  sample carries one beat per sensor reading: count0, count1, elapsed_ms.
//  result returns exactly one beat per sample: lux in signed Q24.8 plus the
//  gain, timing and profile step in effect after the reading.
//  cfg writes one register per beat (index, data); always ready. Write it
//  only while no sample is in flight. Unknown indexes are dropped.
// Sequencing:
//  One sample at a time. Saturated, zero or high-ratio readings skip the
//  arithmetic. Otherwise the work runs on one bit-serial multiplier and one
//  restoring divider: ratio >= 0.5: 3 products; ratio < 0.5: 1 quotient
//  and 4 products; manual timing adds one quotient.
// Reset: registers take their documented defaults, step and settle timer
//  clear, no result pending. No clearing pass.
// Stall: the finished result sits in an output register; the next sample is
//  taken while it waits, and its own result holds until the register frees.
// ----------------------------------------------------------------------------
`include "auto_ranging_lux_calculator_macros.svh"

module auto_ranging_lux_calculator import arl_pkg::*; #(
  parameter int MAX_STEPS         = MAX_STEPS_DEF,
  parameter int POW_TABLE_ENTRIES = POW_ENTRIES_DEF
) (
  input logic          clk,
  input logic          rst,
  arl_sample_if.sink   sample,
  arl_result_if.source result,
  arl_cfg_if.sink      cfg
);
  localparam int IDX_W = $clog2(POW_TABLE_ENTRIES + 1);
  localparam int P_W   = 17 + IDX_W;

  // power table, folded to constants
  logic [15:0] pow_tab [POW_TABLE_ENTRIES+1];
  for (genvar g = 0; g <= POW_TABLE_ENTRIES; g++) begin : g_pow
    localparam int unsigned PX = (g * 32768) / POW_TABLE_ENTRIES;
    assign pow_tab[g] = pow_entry(PX);
  end

  // configuration registers
  logic [1:0]  range_profile;
  logic [15:0] low_limit;
  logic [15:0] high_limit;
  logic        fixed_high_gain;
  logic [1:0]  fixed_timing;
  logic [23:0] manual_time_us;
  logic [15:0] settle_ms;

  // ranging state
  logic [2:0]  current_step;
  logic [15:0] ms_since_change;

  // control
  state_t state, state_next;
  logic   launched, launched_next;
  logic   mul_start, div_start;
  unit_stat_t mul_stat, div_stat;

  // per-sample holding registers
  logic [15:0] c0, c1;
  logic        gain_pre;
  logic [1:0]  timing_pre;
  region_t     region;
  logic [31:0] lux_res;
  logic        sat_r, chg_r, gain_post;
  logic [1:0]  timing_post;
  logic [2:0]  step_post;
  logic [IDX_W-1:0] idx;
  logic [14:0] frac;
  logic [15:0] pw;
  logic [19:0] tmp;
  logic [34:0] acc;
  logic [35:0] raw;
  logic [34:0] scale;

  // output register
  logic               out_valid;
  logic signed [31:0] o_lux;
  logic               o_sat, o_gain, o_chg;
  logic [1:0]         o_timing;
  logic [2:0]         o_step;
  logic [15:0]        o_c0, o_c1;

  logic accept, cfg_we, out_load;
  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;
  assign cfg_we       = cfg.valid;
  assign out_load     = (state == S_FIN) && (!out_valid || result.ready);

  // ---- ranging decision, taken at accept ----
  logic [3:0]  steps_n;
  logic [3:0]  len4;
  logic [16:0] ms_sum;
  logic [15:0] ms_sat;
  logic        low_c, high_c, chg;
  logic [2:0]  step_new;
  logic [15:0] ms_new;

  assign len4    = {1'b0, prof_len(range_profile)};
  assign steps_n = (len4 > 4'(MAX_STEPS)) ? 4'(MAX_STEPS) : len4;
  assign ms_sum  = {1'b0, ms_since_change} + {1'b0, sample.elapsed_ms};
  assign ms_sat  = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
  assign low_c   = (sample.count0 < low_limit) || (sample.count1 < low_limit);
  assign high_c  = (sample.count0 > high_limit) || (sample.count1 > high_limit);

  always_comb begin
    chg      = 1'b0;
    step_new = current_step;
    if (range_profile != 2'd0 && ms_sat > settle_ms) begin
      if (low_c && ({1'b0, current_step} + 4'd1) < steps_n) begin
        step_new = current_step + 3'd1;
        chg      = 1'b1;
      end else if (high_c && current_step != 3'd0) begin
        // a step past the end drops to the last one
        step_new = ({1'b0, current_step} >= steps_n) ? 3'(steps_n - 4'd1)
                                                     : current_step - 3'd1;
        chg      = 1'b1;
      end
    end
    ms_new = chg ? 16'd0 : ms_sat;
  end

  // gain and timing for a step
  logic [2:0] s_pre, s_post;
  logic       g_pre, g_post;
  logic [1:0] t_pre, t_post;

  assign s_pre  = ({1'b0, current_step} >= steps_n) ? 3'(steps_n - 4'd1) : current_step;
  assign s_post = ({1'b0, step_new} >= steps_n) ? 3'(steps_n - 4'd1) : step_new;
  assign g_pre  = (range_profile == 2'd0) ? fixed_high_gain : prof_gain(range_profile, s_pre);
  assign t_pre  = (range_profile == 2'd0) ? fixed_timing : prof_time(range_profile, s_pre);
  assign g_post = (range_profile == 2'd0) ? fixed_high_gain : prof_gain(range_profile, s_post);
  assign t_post = (range_profile == 2'd0) ? fixed_timing : prof_time(range_profile, s_post);

  // ---- region and special cases ----
  logic    in_sat, in_zero;
  region_t rgn;
  assign in_sat  = (sample.count0 == 16'hFFFF) || (sample.count1 == 16'hFFFF);
  assign in_zero = (sample.count0 == 16'd0) || (sample.count1 == 16'd0);

  always_comb begin
    if ({sample.count1, 1'b0} < {1'b0, sample.count0})
      rgn = RGN_POW;
    else if (23'(sample.count1) * 23'd100 < 23'(sample.count0) * 23'd61)
      rgn = RGN_B;
    else if (19'(sample.count1) * 19'd5 < 19'(sample.count0) * 19'd4)
      rgn = RGN_C;
    else if (20'(sample.count1) * 20'd10 < 20'(sample.count0) * 20'd13)
      rgn = RGN_D;
    else
      rgn = RGN_NONE;
  end

  // ---- arithmetic units ----
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [DIV_N_W-1:0] div_n, quot;
  logic [DIV_D_W-1:0] div_d;
  logic [23:0]        us_eff;
  logic [36:0]        raw_rnd;
  logic [23:0]        r12;
  logic [15:0]        diff;

  assign us_eff  = (manual_time_us == 24'd0) ? 24'd1 : manual_time_us;
  assign raw_rnd = {1'b0, raw} + 37'd2048;
  assign r12     = raw_rnd[35:12];
  assign diff    = pow_tab[idx + IDX_W'(1)] - pow_tab[idx];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_D:  begin mul_a = MUL_A_W'(diff);    mul_b = MUL_B_W'(frac); end
      S_MUL_P:  begin mul_a = MUL_A_W'(COEF_P1); mul_b = MUL_B_W'(pw);   end
      S_MUL_R1: begin mul_a = MUL_A_W'(tmp);     mul_b = MUL_B_W'(c0);   end
      S_MUL_A: begin
        mul_b = MUL_B_W'(c0);
        case (region)
          RGN_B:   mul_a = MUL_A_W'(COEF_BA);
          RGN_C:   mul_a = MUL_A_W'(COEF_CA);
          default: mul_a = MUL_A_W'(COEF_DA);
        endcase
      end
      S_MUL_B: begin
        mul_b = MUL_B_W'(c1);
        case (region)
          RGN_B:   mul_a = MUL_A_W'(COEF_BB);
          RGN_C:   mul_a = MUL_A_W'(COEF_CB);
          default: mul_a = MUL_A_W'(COEF_DB);
        endcase
      end
      S_MUL_L:  begin mul_a = scale; mul_b = r12; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    if (state == S_DIV_R) begin
      div_n = DIV_N_W'({c1, 16'h0000});
      div_d = DIV_D_W'(c0);
    end else begin
      div_n = SCALE_NUM + DIV_N_W'(us_eff >> 1);
      div_d = us_eff;
    end
  end

  arl_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod),
    .stat    (mul_stat)
  );

  arl_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quot),
    .stat     (div_stat)
  );

  // ---- sequencer ----
  logic mul_ok, div_ok;
  assign mul_ok = launched && mul_stat.done;
  assign div_ok = launched && div_stat.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_sat || in_zero || rgn == RGN_NONE) state_next = S_FIN;
          else if (rgn == RGN_POW) state_next = S_DIV_R;
          else state_next = S_MUL_A;
        end
      end
      S_DIV_R: begin
        if (!launched) begin
          div_start = 1'b1; launched_next = 1'b1;
        end else if (div_ok) begin
          launched_next = 1'b0; state_next = S_MUL_D;
        end
      end
      S_MUL_D, S_MUL_P, S_MUL_R1, S_MUL_A, S_MUL_B, S_MUL_L: begin
        if (!launched) begin
          mul_start = 1'b1; launched_next = 1'b1;
        end else if (mul_ok) begin
          launched_next = 1'b0;
          case (state)
            S_MUL_D:  state_next = S_MUL_P;
            S_MUL_P:  state_next = S_MUL_R1;
            S_MUL_A:  state_next = S_MUL_B;
            S_MUL_L:  state_next = S_FIN;
            default:  state_next = S_SCALE;
          endcase
        end
      end
      S_SCALE: begin
        if (timing_pre != TIM_MANUAL) begin
          state_next = S_MUL_L;
        end else if (!launched) begin
          div_start = 1'b1; launched_next = 1'b1;
        end else if (div_ok) begin
          launched_next = 1'b0; state_next = S_MUL_L;
        end
      end
      S_FIN: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next    = S_IDLE;
        launched_next = 1'b0;
      end
    endcase
  end

  // ---- configuration and ranging state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      range_profile   <= 2'd0;
      low_limit       <= 16'd100;
      high_limit      <= 16'd5000;
      fixed_high_gain <= 1'b0;
      fixed_timing    <= 2'd0;
      manual_time_us  <= 24'd402000;
      settle_ms       <= 16'd1000;
      current_step    <= 3'd0;
      ms_since_change <= 16'd0;
    end else begin
      if (accept) begin
        current_step    <= step_new;
        ms_since_change <= ms_new;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg.index))
          CFG_RANGE_PROFILE: begin
            range_profile   <= cfg.data[1:0];
            current_step    <= 3'd0;
            ms_since_change <= 16'd0;
          end
          CFG_LOW_LIMIT:       low_limit       <= cfg.data[15:0];
          CFG_HIGH_LIMIT:      high_limit      <= cfg.data[15:0];
          CFG_FIXED_HIGH_GAIN: fixed_high_gain <= cfg.data[0];
          CFG_FIXED_TIMING:    fixed_timing    <= cfg.data[1:0];
          CFG_MANUAL_TIME_US:  manual_time_us  <= cfg.data;
          CFG_SETTLE_MS:       settle_ms       <= cfg.data[15:0];
          default: ;
        endcase
      end
    end
  end

  // ---- datapath ----
  logic [P_W-1:0]  ratio_p;
  logic [P_W-16:0] ratio_i;
  logic [62:0]     prod_g;
  logic [63:0]     lux_rnd;
  logic [43:0]     lux_full;

  assign ratio_p  = P_W'(quot[16:0]) * P_W'(POW_TABLE_ENTRIES);
  assign ratio_i  = ratio_p[P_W-1:15];
  assign prod_g   = gain_pre ? 63'(prod) : {prod, 4'b0000};
  assign lux_rnd  = {1'b0, prod_g} + 64'd524288;
  assign lux_full = lux_rnd[63:20];

  always_ff @(posedge clk) begin
    if (accept) begin
      c0          <= sample.count0;
      c1          <= sample.count1;
      gain_pre    <= g_pre;
      timing_pre  <= t_pre;
      region      <= rgn;
      sat_r       <= in_sat;
      lux_res     <= in_sat ? 32'hFFFFFF00 : 32'd0;
      chg_r       <= chg;
      gain_post   <= g_post;
      timing_post <= t_post;
      step_post   <= step_new;
    end
    if (state == S_DIV_R && div_ok) begin
      // index clamps to the last interval
      idx  <= (ratio_i >= (P_W-15)'(POW_TABLE_ENTRIES)) ? IDX_W'(POW_TABLE_ENTRIES - 1)
                                                       : IDX_W'(ratio_i);
      frac <= ratio_p[14:0];
    end
    if (mul_ok) begin
      case (state)
        S_MUL_D:  pw  <= pow_tab[idx] + 16'(prod >> 15);
        S_MUL_P:  tmp <= 20'(COEF_P0) - 20'(prod >> 16);
        S_MUL_R1: raw <= tmp[19] ? 36'd0 : prod[35:0];
        S_MUL_A:  acc <= prod[34:0];
        S_MUL_B:  raw <= (MUL_P_W'(acc) >= prod) ? 36'(MUL_P_W'(acc) - prod) : 36'd0;
        S_MUL_L:  lux_res <= (lux_full > 44'h7FFFFFFF) ? 32'h7FFFFFFF : lux_full[31:0];
        default: ;
      endcase
    end
    if (state == S_SCALE) begin
      case (timing_pre)
        TIM_13MS:  scale <= SCALE_T0;
        TIM_101MS: scale <= SCALE_T1;
        TIM_402MS: scale <= SCALE_T2;
        default:   scale <= quot;
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_lux    <= lux_res;
      o_sat    <= sat_r;
      o_gain   <= gain_post;
      o_timing <= timing_post;
      o_step   <= step_post;
      o_chg    <= chg_r;
      o_c0     <= c0;
      o_c1     <= c1;
    end
  end

  assign result.valid         = out_valid;
  assign result.lux_q8        = o_lux;
  assign result.saturated     = o_sat;
  assign result.gain_high     = o_gain;
  assign result.timing_sel    = o_timing;
  assign result.step_index    = o_step;
  assign result.range_changed = o_chg;
  assign result.count0_echo   = o_c0;
  assign result.count1_echo   = o_c1;

  // ---- checks ----
  `ARL_ASSERT_NEVER(a_units_exclusive, mul_stat.busy && div_stat.busy)
  `ARL_ASSERT(a_step_bound, (range_profile != 2'd0) |-> ({1'b0, current_step} < steps_n))
  `ARL_ASSERT(a_sat_fast, (accept && in_sat) |=> (state == S_FIN))
  `ARL_ASSERT(a_sat_value, (result.valid && result.saturated) |-> (result.lux_q8 == -32'sd256))
endmodule
